// ===== sv/mksd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mksd_pkg
// Shared types and constants of the morse key symbol decoder.
// ----------------------------------------------------------------------------
package mksd_pkg;

	localparam int TICK_W       = 16;
	localparam int PATTERN_W    = 8;
	localparam int LENGTH_W     = 4;
	localparam int CFG_INDEX_W  = 3;
	localparam int MAX_SYMBOLS  = 8;

	localparam logic [TICK_W-1:0] DEBOUNCE_HIGH_RST  = 16'd100;
	localparam logic [TICK_W-1:0] LONG_THRESHOLD_RST = 16'd400;
	localparam logic [TICK_W-1:0] DEBOUNCE_LOW_RST   = 16'd100;
	localparam logic [TICK_W-1:0] PAUSE_RST          = 16'd750;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_HIGH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LOW   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PAUSE          = 3'd3;

	// timing values as seen by the sequencer
	typedef struct packed {
		logic [TICK_W-1:0] debounce_high;
		logic [TICK_W-1:0] debounce_low;
		logic [TICK_W-1:0] long_wait;   // long threshold minus high debounce, floored at 0
		logic [TICK_W-1:0] pause_wait;  // pause minus low debounce, floored at 0
	} timing_t;

	// one result item
	typedef struct packed {
		logic                 symbol_valid;
		logic                 symbol_is_dash;
		logic                 char_valid;
		logic [PATTERN_W-1:0] char_pattern;
		logic [LENGTH_W-1:0]  char_length;
		logic                 word_overflow;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/mksd_key_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mksd_key_if
// Input channel: one key sample per tick.
// ----------------------------------------------------------------------------
interface mksd_key_if;
	logic valid;
	logic ready;
	logic key_pressed;

	modport source (output valid, output key_pressed, input ready);
	modport sink   (input valid, input key_pressed, output ready);
endinterface
`default_nettype wire

// ===== sv/mksd_sym_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mksd_sym_if
// Output channel: symbol and character results, one per tick.
// ----------------------------------------------------------------------------
interface mksd_sym_if;
	logic       valid;
	logic       ready;
	logic       symbol_valid;
	logic       symbol_is_dash;
	logic       char_valid;
	logic [7:0] char_pattern;
	logic [3:0] char_length;
	logic       word_overflow;

	modport source (output valid, output symbol_valid, output symbol_is_dash,
		output char_valid, output char_pattern, output char_length,
		output word_overflow, input ready);
	modport sink   (input valid, input symbol_valid, input symbol_is_dash,
		input char_valid, input char_pattern, input char_length,
		input word_overflow, output ready);
endinterface
`default_nettype wire

// ===== sv/mksd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mksd_cfg_regs
// Timing registers and the derived saturating waits.
// ----------------------------------------------------------------------------
module mksd_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mksd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mksd_pkg::TICK_W-1:0]      cfg_data,
	output mksd_pkg::timing_t                     timing
);
	import mksd_pkg::*;

	logic [TICK_W-1:0] debounce_high_q;
	logic [TICK_W-1:0] long_threshold_q;
	logic [TICK_W-1:0] debounce_low_q;
	logic [TICK_W-1:0] pause_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_high_q  <= DEBOUNCE_HIGH_RST;
			long_threshold_q <= LONG_THRESHOLD_RST;
			debounce_low_q   <= DEBOUNCE_LOW_RST;
			pause_q          <= PAUSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE_HIGH:  debounce_high_q  <= cfg_data;
				REG_LONG_THRESHOLD: long_threshold_q <= cfg_data;
				REG_DEBOUNCE_LOW:   debounce_low_q   <= cfg_data;
				REG_PAUSE:          pause_q          <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	always_comb begin
		timing.debounce_high = debounce_high_q;
		timing.debounce_low  = debounce_low_q;
		timing.long_wait     = (long_threshold_q > debounce_high_q) ?
			long_threshold_q - debounce_high_q : '0;
		timing.pause_wait    = (pause_q > debounce_low_q) ?
			pause_q - debounce_low_q : '0;
	end
endmodule
`default_nettype wire

// ===== sv/mksd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mksd_seq
// Tick sequencer: debounce, dot/dash timing, pause detection, word buffer.
// ----------------------------------------------------------------------------
module mksd_seq #(
	parameter int MAX_SYMBOLS = mksd_pkg::MAX_SYMBOLS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,      // an input transfer this cycle
	input  wire logic              key,
	input  wire mksd_pkg::timing_t timing,
	output mksd_pkg::result_t      result
);
	import mksd_pkg::*;

	localparam int WORD_CAP = (MAX_SYMBOLS < PATTERN_W) ? MAX_SYMBOLS : PATTERN_W;
	localparam logic [LENGTH_W-1:0] CAP = LENGTH_W'(WORD_CAP);

	typedef enum logic [2:0] {
		IDLE      = 3'd0,
		DEB_HIGH  = 3'd1,
		WAIT_LONG = 3'd2,
		DEB_LOW   = 3'd3,
		PAUSE     = 3'd4
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [TICK_W-1:0]    cnt_q, cnt_d;
	logic                 armed_q, armed_d;
	logic                 prev_q;
	logic [PATTERN_W-1:0] pat_q, pat_d;
	logic [LENGTH_W-1:0]  count_q, count_d;
	logic                 press_edge;

	assign press_edge = key & ~prev_q;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		armed_d = armed_q;
		pat_d   = pat_q;
		count_d = count_q;
		result  = '0;

		if ((phase_q == IDLE || phase_q == PAUSE) && armed_q && press_edge) begin
			phase_d = DEB_HIGH;
			cnt_d   = timing.debounce_high;
			armed_d = 1'b0;
		end else if (phase_q != IDLE) begin
			if (cnt_q > TICK_W'(1)) begin
				cnt_d = cnt_q - TICK_W'(1);
			end else begin
				cnt_d = '0;
				unique case (phase_q)
					DEB_HIGH: begin
						if (key) begin
							phase_d = WAIT_LONG;
							cnt_d   = timing.long_wait;
						end else begin
							phase_d = IDLE;
							armed_d = 1'b1;
						end
					end
					WAIT_LONG: begin
						result.symbol_valid   = 1'b1;
						result.symbol_is_dash = key;
						if (count_q >= CAP) begin
							result.word_overflow = 1'b1;
							pat_d   = '0;
							count_d = '0;
						end else begin
							if (key) pat_d[count_q[2:0]] = 1'b1;
							count_d = count_q + LENGTH_W'(1);
						end
						phase_d = DEB_LOW;
						cnt_d   = timing.debounce_low;
					end
					DEB_LOW: begin
						if (key) begin
							cnt_d = timing.debounce_low;  // key still down, restart
						end else begin
							phase_d = PAUSE;
							armed_d = 1'b1;
							cnt_d   = timing.pause_wait;
						end
					end
					PAUSE: begin
						result.char_valid   = 1'b1;
						result.char_pattern = pat_q;
						result.char_length  = count_q;
						pat_d   = '0;
						count_d = '0;
						phase_d = IDLE;
						armed_d = 1'b1;
					end
					default: begin
						phase_d = IDLE;
						armed_d = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= IDLE;
			cnt_q   <= '0;
			armed_q <= 1'b1;
			prev_q  <= 1'b0;
			pat_q   <= '0;
			count_q <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			armed_q <= armed_d;
			prev_q  <= key;
			pat_q   <= pat_d;
			count_q <= count_d;
		end
	end
endmodule
`default_nettype wire

// ===== sv/mksd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mksd_out_reg
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module mksd_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire mksd_pkg::result_t result,
	output logic                   full,
	mksd_sym_if.source             sym
);
	import mksd_pkg::*;

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (sym.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= result;
	end

	assign full               = valid_q;
	assign sym.valid          = valid_q;
	assign sym.symbol_valid   = data_q.symbol_valid;
	assign sym.symbol_is_dash = data_q.symbol_is_dash;
	assign sym.char_valid     = data_q.char_valid;
	assign sym.char_pattern   = data_q.char_pattern;
	assign sym.char_length    = data_q.char_length;
	assign sym.word_overflow  = data_q.word_overflow;
endmodule
`default_nettype wire

// ===== sv/morse_key_symbol_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A key sample's result is registered and appears on the output channel in the cycle after its transfer.
// Throughput: one sample per cycle; the single result register refills in the
// cycle it is taken, so only a stalled output holds the input back.
// Reset: arst_n clears the sequencer to idle, armed, key released, empty word,
// and loads the timing registers with 100/400/100/750 ticks. No clearing pass.
// ----------------------------------------------------------------------------
// morse_key_symbol_decoder
// Turns timed key samples into dots, dashes and finished character patterns.
// ----------------------------------------------------------------------------
module morse_key_symbol_decoder #(
	parameter int MAX_SYMBOLS = mksd_pkg::MAX_SYMBOLS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	mksd_key_if.sink                              key,
	mksd_sym_if.source                            sym,
	input  wire logic                             cfg_we,
	input  wire logic [mksd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mksd_pkg::TICK_W-1:0]      cfg_data
);
	import mksd_pkg::*;

	timing_t timing;      // current tick counts and derived waits
	result_t result;      // result of the sample being transferred
	logic    out_full;    // result register holds an untaken item
	logic    tick;        // input transfer this cycle

	// Accept whenever the result register is empty or drains this cycle.
	assign key.ready = ~out_full | sym.ready;
	assign tick      = key.valid & key.ready;

	mksd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	// All sequencer state advances only on a transfer; idle cycles are not ticks.
	mksd_seq #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.key    (key.key_pressed),
		.timing (timing),
		.result (result)
	);

	mksd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (tick),
		.result (result),
		.full   (out_full),
		.sym    (sym)
	);

	// A symbol and a character end come from different phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		sym.valid |-> !(sym.symbol_valid && sym.char_valid))
		else $error("symbol and character reported in one result");

	// Overflow and dash flags only ride along with a symbol.
	assert property (@(posedge clk) disable iff (!arst_n)
		sym.valid && (sym.word_overflow || sym.symbol_is_dash) |-> sym.symbol_valid)
		else $error("overflow or dash without symbol");

	// An empty result register never holds back the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_full |-> key.ready)
		else $error("input stalled with empty result register");

	// A transfer always leaves a result waiting on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> sym.valid)
		else $error("transfer produced no result");

endmodule
`default_nettype wire
